### sv/pdll_pkg.sv
package pdll_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int PTR_W  = $clog2(DEPTH + 1);
	localparam int OP_W   = 2;
	localparam int POS_W  = 5;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 5;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [PTR_W-1:0]         ptr_t;
	typedef logic signed [DATA_W-1:0] word_t;

	localparam ptr_t NIL       = PTR_W'(DEPTH);
	localparam ptr_t DEPTH_PTR = PTR_W'(DEPTH);

	typedef enum logic [OP_W-1:0] {
		OP_INS_HEAD = 2'd0,
		OP_INS_TAIL = 2'd1,
		OP_INS_POS  = 2'd2,
		OP_DEL_POS  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD_POS = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_DEL_RD,
		S_DEL_WR,
		S_DEL_FIX,
		S_INS_RD,
		S_INS_WR1,
		S_INS_WR2,
		S_RESP
	} state_t;

endpackage

### sv/pdll_req_if.sv
interface pdll_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [pdll_pkg::OP_W-1:0]            op;
	logic [pdll_pkg::POS_W-1:0]           position;
	logic signed [31:0]                   value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink (input valid, input op, input position, input value, output ready);
endinterface

### sv/pdll_rsp_if.sv
interface pdll_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [pdll_pkg::STAT_W-1:0]  status;
	logic signed [31:0]           removed_value;
	logic [pdll_pkg::LEN_W-1:0]   list_length;
	logic signed [31:0]           head_value;
	logic signed [31:0]           tail_value;

	modport source (output valid, output status, output removed_value, output list_length,
		output head_value, output tail_value, input ready);
	modport sink (input valid, input status, input removed_value, input list_length,
		input head_value, input tail_value, output ready);
endinterface

### sv/positional_doubly_linked_list.sv
// Bounded doubly linked list of 16 signed 32-bit words.
// req channel: one beat per request (op, position, value). Ops insert at the
// head, at the tail, before a one-based position (length+1 appends), or
// delete the node at a one-based position.
// rsp channel: exactly one beat per request with status (ok, bad position,
// pool full), the removed word, the new length and the head and tail words.
// Positional inserts (other than appends at position length+1) and deletes
// first walk the links: one next-link memory read per cycle, the read data
// feeding the next address. Head and tail inserts, appends and rejected
// requests skip the walk.
// One request is worked on at a time; the next request is taken the cycle
// after the response is loaded, even if that response still waits.
// A stalled rsp holds its beat; the block then waits with the next result
// until the beat is taken.
// Reset empties the list and refills the free-node stack at once; node
// memories are not cleared and need no clearing pass.
module positional_doubly_linked_list (
	input  logic              clk,
	input  logic              arst_n,
	pdll_req_if.sink          req,
	pdll_rsp_if.source        rsp
);

	pdll_pkg::state_t  state_q, state_d;

	// node memories, registered read
	pdll_pkg::word_t   val_mem [pdll_pkg::DEPTH];
	pdll_pkg::ptr_t    nxt_mem [pdll_pkg::DEPTH];
	pdll_pkg::ptr_t    prv_mem [pdll_pkg::DEPTH];

	pdll_pkg::word_t   val_rdata;
	pdll_pkg::ptr_t    nxt_rdata, prv_rdata;
	pdll_pkg::idx_t    val_raddr, nxt_raddr, prv_raddr;
	logic              val_we, nxt_we, prv_we;
	pdll_pkg::idx_t    val_waddr, nxt_waddr, prv_waddr;
	pdll_pkg::word_t   val_wdata;
	pdll_pkg::ptr_t    nxt_wdata, prv_wdata;

	pdll_pkg::idx_t    fs_q [pdll_pkg::DEPTH];

	pdll_pkg::ptr_t    head_q, tail_q, count_q;
	pdll_pkg::word_t   head_val_q, tail_val_q;

	pdll_pkg::op_t     op_q;
	pdll_pkg::word_t   val_q;
	pdll_pkg::idx_t    cnt_q;
	pdll_pkg::ptr_t    cur_q, at_q, p_q, q_q, before_q;
	pdll_pkg::idx_t    n_q;
	logic              first_q;
	pdll_pkg::status_t status_q;
	pdll_pkg::word_t   removed_q;

	logic              rsp_valid_q;
	pdll_pkg::status_t rsp_status_q;
	pdll_pkg::word_t   rsp_removed_q, rsp_head_q, rsp_tail_q;
	logic [pdll_pkg::LEN_W-1:0] rsp_len_q;

	pdll_pkg::ptr_t    cur_c, before_c;
	pdll_pkg::idx_t    pop_idx, push_idx;
	logic              req_fire, rsp_load;
	logic              del_bad, ins_bad, full, need_walk;
	logic [pdll_pkg::PTR_W:0] pos_ext, cnt_ext;

	assign cur_c    = first_q ? cur_q : nxt_rdata;
	assign before_c = (at_q == pdll_pkg::NIL) ? tail_q : prv_rdata;
	assign pop_idx  = pdll_pkg::IDX_W'(pdll_pkg::DEPTH_PTR - count_q - 1'b1);
	assign push_idx = pdll_pkg::IDX_W'(pdll_pkg::DEPTH_PTR - count_q);

	assign pos_ext   = (pdll_pkg::PTR_W + 1)'(req.position);
	assign cnt_ext   = (pdll_pkg::PTR_W + 1)'(count_q);
	assign del_bad   = (req.position == '0) || (pos_ext > cnt_ext);
	assign ins_bad   = (pdll_pkg::op_t'(req.op) == pdll_pkg::OP_INS_POS) &&
		((req.position == '0) || (pos_ext > cnt_ext + 1'b1));
	assign full      = (count_q == pdll_pkg::DEPTH_PTR);
	assign need_walk = (pdll_pkg::op_t'(req.op) == pdll_pkg::OP_INS_POS) && (pos_ext <= cnt_ext);

	assign req.ready = (state_q == pdll_pkg::S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_load  = (state_q == pdll_pkg::S_RESP) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdll_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		val_raddr = at_q[pdll_pkg::IDX_W-1:0];
		nxt_raddr = at_q[pdll_pkg::IDX_W-1:0];
		prv_raddr = at_q[pdll_pkg::IDX_W-1:0];
		val_we    = 1'b0;
		nxt_we    = 1'b0;
		prv_we    = 1'b0;
		val_waddr = n_q;
		nxt_waddr = n_q;
		prv_waddr = n_q;
		val_wdata = val_q;
		nxt_wdata = at_q;
		prv_wdata = before_c;
		case (state_q)
			pdll_pkg::S_IDLE: begin
				if (req_fire) begin
					if (pdll_pkg::op_t'(req.op) == pdll_pkg::OP_DEL_POS) begin
						state_d = del_bad ? pdll_pkg::S_RESP : pdll_pkg::S_WALK;
					end else if (ins_bad || full) begin
						state_d = pdll_pkg::S_RESP;
					end else begin
						state_d = need_walk ? pdll_pkg::S_WALK : pdll_pkg::S_INS_RD;
					end
				end
			end
			pdll_pkg::S_WALK: begin
				// follow one next link per cycle
				nxt_raddr = cur_c[pdll_pkg::IDX_W-1:0];
				if (cnt_q == '0) begin
					state_d = (op_q == pdll_pkg::OP_DEL_POS) ? pdll_pkg::S_DEL_RD
						: pdll_pkg::S_INS_RD;
				end
			end
			pdll_pkg::S_DEL_RD: begin
				state_d = pdll_pkg::S_DEL_WR;
			end
			pdll_pkg::S_DEL_WR: begin
				// unlink: prev -> next and next -> prev
				val_raddr = (prv_rdata == pdll_pkg::NIL) ? nxt_rdata[pdll_pkg::IDX_W-1:0]
					: prv_rdata[pdll_pkg::IDX_W-1:0];
				nxt_we    = (prv_rdata != pdll_pkg::NIL);
				nxt_waddr = prv_rdata[pdll_pkg::IDX_W-1:0];
				nxt_wdata = nxt_rdata;
				prv_we    = (nxt_rdata != pdll_pkg::NIL);
				prv_waddr = nxt_rdata[pdll_pkg::IDX_W-1:0];
				prv_wdata = prv_rdata;
				state_d   = pdll_pkg::S_DEL_FIX;
			end
			pdll_pkg::S_DEL_FIX: begin
				state_d = pdll_pkg::S_RESP;
			end
			pdll_pkg::S_INS_RD: begin
				state_d = pdll_pkg::S_INS_WR1;
			end
			pdll_pkg::S_INS_WR1: begin
				val_we    = 1'b1;
				val_waddr = fs_q[pop_idx];
				nxt_we    = 1'b1;
				nxt_waddr = fs_q[pop_idx];
				nxt_wdata = at_q;
				prv_we    = 1'b1;
				prv_waddr = fs_q[pop_idx];
				prv_wdata = before_c;
				state_d   = pdll_pkg::S_INS_WR2;
			end
			pdll_pkg::S_INS_WR2: begin
				// hook the neighbors onto the new node
				nxt_we    = (before_q != pdll_pkg::NIL);
				nxt_waddr = before_q[pdll_pkg::IDX_W-1:0];
				nxt_wdata = pdll_pkg::PTR_W'(n_q);
				prv_we    = (at_q != pdll_pkg::NIL);
				prv_waddr = at_q[pdll_pkg::IDX_W-1:0];
				prv_wdata = pdll_pkg::PTR_W'(n_q);
				state_d   = pdll_pkg::S_RESP;
			end
			pdll_pkg::S_RESP: begin
				if (rsp_load) begin
					state_d = pdll_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pdll_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_waddr] <= val_wdata;
		end
		val_rdata <= val_mem[val_raddr];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_waddr] <= nxt_wdata;
		end
		nxt_rdata <= nxt_mem[nxt_raddr];
	end

	always_ff @(posedge clk) begin
		if (prv_we) begin
			prv_mem[prv_waddr] <= prv_wdata;
		end
		prv_rdata <= prv_mem[prv_raddr];
	end

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pdll_pkg::DEPTH; i++) begin
				fs_q[i] <= pdll_pkg::IDX_W'(pdll_pkg::DEPTH - 1 - i);
			end
			head_q  <= pdll_pkg::NIL;
			tail_q  <= pdll_pkg::NIL;
			count_q <= '0;
		end else begin
			if (state_q == pdll_pkg::S_DEL_WR) begin
				if (prv_rdata == pdll_pkg::NIL) begin
					head_q <= nxt_rdata;
				end
				if (nxt_rdata == pdll_pkg::NIL) begin
					tail_q <= prv_rdata;
				end
				fs_q[push_idx] <= at_q[pdll_pkg::IDX_W-1:0];
				count_q        <= count_q - 1'b1;
			end
			if (state_q == pdll_pkg::S_INS_WR1) begin
				if (before_c == pdll_pkg::NIL) begin
					head_q <= pdll_pkg::PTR_W'(fs_q[pop_idx]);
				end
				if (at_q == pdll_pkg::NIL) begin
					tail_q <= pdll_pkg::PTR_W'(fs_q[pop_idx]);
				end
				count_q <= count_q + 1'b1;
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		case (state_q)
			pdll_pkg::S_IDLE: begin
				if (req_fire) begin
					op_q      <= pdll_pkg::op_t'(req.op);
					val_q     <= req.value;
					cnt_q     <= pdll_pkg::IDX_W'(req.position - 1'b1);
					cur_q     <= head_q;
					first_q   <= 1'b1;
					removed_q <= '0;
					at_q      <= (pdll_pkg::op_t'(req.op) == pdll_pkg::OP_INS_HEAD) ? head_q
						: pdll_pkg::NIL;
					if (pdll_pkg::op_t'(req.op) == pdll_pkg::OP_DEL_POS) begin
						status_q <= del_bad ? pdll_pkg::STAT_BAD_POS : pdll_pkg::STAT_OK;
					end else if (ins_bad) begin
						status_q <= pdll_pkg::STAT_BAD_POS;
					end else if (full) begin
						status_q <= pdll_pkg::STAT_FULL;
					end else begin
						status_q <= pdll_pkg::STAT_OK;
					end
				end
			end
			pdll_pkg::S_WALK: begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					at_q <= cur_c;
				end
			end
			pdll_pkg::S_DEL_WR: begin
				removed_q <= val_rdata;
				p_q       <= prv_rdata;
				q_q       <= nxt_rdata;
			end
			pdll_pkg::S_DEL_FIX: begin
				if (p_q == pdll_pkg::NIL) begin
					head_val_q <= val_rdata;
				end
				if (q_q == pdll_pkg::NIL) begin
					tail_val_q <= val_rdata;
				end
			end
			pdll_pkg::S_INS_WR1: begin
				n_q      <= fs_q[pop_idx];
				before_q <= before_c;
				if (before_c == pdll_pkg::NIL) begin
					head_val_q <= val_q;
				end
				if (at_q == pdll_pkg::NIL) begin
					tail_val_q <= val_q;
				end
			end
			default: begin
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q  <= status_q;
			rsp_removed_q <= removed_q;
			rsp_len_q     <= pdll_pkg::LEN_W'(count_q);
			rsp_head_q    <= (count_q != '0) ? head_val_q : '0;
			rsp_tail_q    <= (count_q != '0) ? tail_val_q : '0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.removed_value = rsp_removed_q;
	assign rsp.list_length   = rsp_len_q;
	assign rsp.head_value    = rsp_head_q;
	assign rsp.tail_value    = rsp_tail_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pdll_pkg::DEPTH_PTR)
		else $error("node count above pool depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == pdll_pkg::NIL && tail_q == pdll_pkg::NIL))
		else $error("empty list with live head or tail");

	a_nonempty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (head_q != pdll_pkg::NIL && tail_q != pdll_pkg::NIL))
		else $error("non-empty list with null head or tail");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == pdll_pkg::S_DEL_WR ||
		$past(state_q) == pdll_pkg::S_INS_WR1))
		else $error("node count changed outside a link update");
`endif

endmodule
